// File: rtl/ufrsc_pkg.sv
// Shared types and constants for the frame receiver with additive check.
// No dependencies; imported by every module of the block.
package ufrsc_pkg;

    localparam int BYTE_W      = 8;
    localparam int NUM_PAYLOAD = 5;

    // Start byte value after reset
    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;

    // One accepted frame as it leaves the block
    typedef struct packed {
        logic [NUM_PAYLOAD-1:0][BYTE_W-1:0] payload;
        logic [BYTE_W-1:0]                  trailer;
    } frame_result_t;

endpackage

// File: rtl/uart_frame_receiver_sum_check_top.sv
// Top level of the frame receiver with additive check.
// Depends on ufrsc_pkg, ufrsc_collector and ufrsc_out_reg.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry received bytes, one item per byte.
//   m_valid/m_ready carry one item per good frame: m_payload_0..4 and
//   m_trailer. cfg_we/cfg_wdata write the start byte (0xAA after reset).
//   While idle, bytes other than the start byte are discarded. The start
//   byte opens a frame of FRAME_BYTES bytes; a start byte inside a frame is
//   plain data. At frame end the sum of the payload bytes modulo 256 is
//   compared with the check byte; a good frame is presented on m_* in the
//   cycle after its last byte is taken, a bad frame is dropped.
//   Throughput: one byte per cycle while s_ready is high, set by the fill
//   count and running-sum update. A waiting result does not block input: only
//   the last byte of a frame is held off (s_ready low) while an earlier
//   result is still pending and m_ready is low.
//   Reset (aresetn low, synchronous) returns to idle, clears the running
//   sum and pending result and restores the start byte.
module uart_frame_receiver_sum_check_top
    import ufrsc_pkg::*;
#(
    parameter int FRAME_BYTES = 8,
    parameter int PAYLOAD_LEN = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_payload_0,
    output logic [BYTE_W-1:0] m_payload_1,
    output logic [BYTE_W-1:0] m_payload_2,
    output logic [BYTE_W-1:0] m_payload_3,
    output logic [BYTE_W-1:0] m_payload_4,
    output logic [BYTE_W-1:0] m_trailer
);

    logic          in_fire;
    logic          at_last;
    logic          res_valid;
    frame_result_t res;
    frame_result_t out_data;

    // Hold off only a frame-ending byte while the result slot is occupied and not being taken
    assign s_ready = !(at_last && m_valid && !m_ready);
    assign in_fire = s_valid && s_ready;

    ufrsc_collector #(
        .FRAME_BYTES (FRAME_BYTES),
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_collector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_byte   (s_rx_byte),
        .at_last   (at_last),
        .res_valid (res_valid),
        .res       (res)
    );

    ufrsc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_payload_0 = out_data.payload[0];
    assign m_payload_1 = out_data.payload[1];
    assign m_payload_2 = out_data.payload[2];
    assign m_payload_3 = out_data.payload[3];
    assign m_payload_4 = out_data.payload[4];
    assign m_trailer   = out_data.trailer;

endmodule

// File: rtl/ufrsc_collector.sv
// Frame collector: start detection, fill count, frame storage, running sum
// and the check at frame end. Depends on ufrsc_pkg.
module ufrsc_collector
    import ufrsc_pkg::*;
#(
    parameter int FRAME_BYTES = 8,
    parameter int PAYLOAD_LEN = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BYTE_W-1:0]   cfg_wdata,
    input  logic                in_fire,
    input  logic [BYTE_W-1:0]   in_byte,
    output logic                at_last,
    output logic                res_valid,
    output frame_result_t       res
);

    localparam int CNT_W     = $clog2(FRAME_BYTES);
    localparam int CHECK_POS = (PAYLOAD_LEN + 1 < FRAME_BYTES) ?
                               PAYLOAD_LEN + 1 : FRAME_BYTES - 1;
    localparam int SUM_LIMIT = (PAYLOAD_LEN < CHECK_POS - 1) ? PAYLOAD_LEN : CHECK_POS - 1;
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] SUM_LAST = CNT_W'(SUM_LIMIT);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic [BYTE_W-1:0] start_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] store_reg [FRAME_BYTES];
    logic [BYTE_W-1:0] check_byte;

    assign at_last = (fill_reg == LAST_POS);

    // Hold the start byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_BYTE_RESET;
        end else if (cfg_we) begin
            start_reg <= cfg_wdata;
        end
    end

    // Store each frame byte after the start byte at its position; the last byte is used directly
    always_ff @(posedge aclk) begin
        if (in_fire && fill_reg != '0 && !at_last) begin
            store_reg[fill_reg] <= in_byte;
        end
    end

    // Check byte: the incoming byte when it sits at the last position, else the stored byte at CHECK_POS
    generate
        if (CHECK_POS == FRAME_BYTES - 1) begin : g_check_last
            assign check_byte = in_byte;
        end else begin : g_check_store
            assign check_byte = store_reg[CHECK_POS];
        end
    endgenerate

    // Advance the fill count and the running sum, flag a matching frame
    always_comb begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        res_valid = 1'b0;
        if (in_fire) begin
            if (fill_reg == '0) begin
                if (in_byte == start_reg) begin
                    fill_next = ONE;
                    sum_next  = '0;
                end
            end else if (at_last) begin
                fill_next = '0;
                sum_next  = '0;
                res_valid = (sum_reg == check_byte);
            end else begin
                fill_next = fill_reg + ONE;
                if (fill_reg <= SUM_LAST) begin
                    sum_next = sum_reg + in_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // Select payload fields; positions past the payload read as zero
    generate
        for (genvar j = 0; j < NUM_PAYLOAD; j++) begin : g_payload
            if (j < PAYLOAD_LEN && j + 1 == FRAME_BYTES - 1) begin : g_last
                assign res.payload[j] = in_byte;
            end else if (j < PAYLOAD_LEN && j + 1 < FRAME_BYTES - 1) begin : g_stored
                assign res.payload[j] = store_reg[j + 1];
            end else begin : g_zero
                assign res.payload[j] = '0;
            end
        end
    endgenerate

    assign res.trailer = in_byte;

endmodule

// File: rtl/ufrsc_out_reg.sv
// Result register: holds one finished frame until the consumer takes it.
// Depends on ufrsc_pkg.
module ufrsc_out_reg
    import ufrsc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  frame_result_t load_data,
    input  logic          m_ready,
    output logic          m_valid,
    output frame_result_t m_data
);

    logic          valid_reg;
    frame_result_t data_reg;

    // Load a new item or drop the one just taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for uart_frame_receiver_sum_check_top.
// Depends on ufrsc_pkg and the block's RTL; keeps its own frame predictor and
// checks every good frame field by field as it leaves the block.
module tb_top;
    import ufrsc_pkg::*;

    localparam int FRAME_BYTES = 8;
    localparam int PAYLOAD_LEN = 5;
    localparam int CHECK_POS   = (PAYLOAD_LEN + 1 < FRAME_BYTES) ?
                                 PAYLOAD_LEN + 1 : FRAME_BYTES - 1;
    localparam int SETTLE      = 20;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 300000;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [BYTE_W-1:0] m_payload_0, m_payload_1, m_payload_2, m_payload_3, m_payload_4;
    logic [BYTE_W-1:0] m_trailer;

    // Predictor state
    logic [BYTE_W-1:0] cur_start = START_BYTE_RESET;
    logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
    logic [BYTE_W-1:0] rx_sum    = '0;
    int                rx_fill   = 0;

    logic [BYTE_W-1:0] rx_bytes_pending [$];
    frame_result_t     good_frames_due  [$];

    int  bytes_taken   = 0;
    int  frames_seen   = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  tx_gap        = 0;
    int  rx_hold       = 0;
    bit  no_idle       = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;

    uart_frame_receiver_sum_check_top #(
        .FRAME_BYTES(FRAME_BYTES),
        .PAYLOAD_LEN(PAYLOAD_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload_0(m_payload_0),
        .m_payload_1(m_payload_1),
        .m_payload_2(m_payload_2),
        .m_payload_3(m_payload_3),
        .m_payload_4(m_payload_4),
        .m_trailer  (m_trailer)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the frame state by one received byte; queue a good frame when one closes
    task automatic take_byte(input logic [BYTE_W-1:0] b);
        frame_result_t res;
        int j;
        if (rx_fill == 0) begin
            if (b == cur_start) begin
                frame_buf[0] = b;
                rx_sum = '0;
                rx_fill = 1;
            end
            return;
        end
        frame_buf[rx_fill] = b;
        if (rx_fill >= 1 && rx_fill <= PAYLOAD_LEN && rx_fill < CHECK_POS)
            rx_sum = rx_sum + b;
        if (rx_fill + 1 < FRAME_BYTES) begin
            rx_fill++;
            return;
        end
        rx_fill = 0;
        if (rx_sum == frame_buf[CHECK_POS]) begin
            for (j = 0; j < NUM_PAYLOAD; j++)
                res.payload[j] = (j < PAYLOAD_LEN) ? frame_buf[j+1] : '0;
            res.trailer = frame_buf[FRAME_BYTES-1];
            good_frames_due.push_back(res);
        end
        rx_sum = '0;
    endtask

    // Sender: hold each byte until taken, idle in random bursts
    always @(posedge aclk) begin
        logic advance;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            advance = !s_valid || s_ready;
            if (s_valid && s_ready) begin
                take_byte(s_rx_byte);
                bytes_taken++;
            end
            if (advance) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (rx_bytes_pending.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 99) < 12) begin
                    tx_gap = $urandom_range(1, 13) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_rx_byte <= rx_bytes_pending.pop_front();
                    s_valid   <= 1'b1;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 10) begin
            rx_hold = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_byte(input string field, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %02h got %02h", $time, field, want, got);
        end
    endtask

    // Compare every delivered frame with the oldest one due
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (good_frames_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected frame, expected none got %02h %02h %02h %02h %02h %02h",
                         $time, m_payload_0, m_payload_1, m_payload_2, m_payload_3,
                         m_payload_4, m_trailer);
            end else begin
                want = good_frames_due.pop_front();
                check_byte("payload_0", want.payload[0], m_payload_0);
                check_byte("payload_1", want.payload[1], m_payload_1);
                check_byte("payload_2", want.payload[2], m_payload_2);
                check_byte("payload_3", want.payload[3], m_payload_3);
                check_byte("payload_4", want.payload[4], m_payload_4);
                check_byte("trailer", want.trailer, m_trailer);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames still due",
                     cycle_count, good_frames_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_frame(input bit good_sum, input bit start_inside);
        logic [BYTE_W-1:0] body [PAYLOAD_LEN];
        logic [BYTE_W-1:0] sum;
        int k;
        sum = '0;
        for (k = 0; k < PAYLOAD_LEN; k++) begin
            body[k] = BYTE_W'($urandom_range(0, 255));
            if (start_inside && $urandom_range(0, 2) == 0)
                body[k] = cur_start;
            sum = sum + body[k];
        end
        rx_bytes_pending.push_back(cur_start);
        for (k = 0; k < PAYLOAD_LEN; k++)
            rx_bytes_pending.push_back(body[k]);
        rx_bytes_pending.push_back(good_sum ? sum : sum ^ BYTE_W'($urandom_range(1, 255)));
        rx_bytes_pending.push_back(start_inside ? cur_start : BYTE_W'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed frames, some with bad sums, some cut short, some noise
    task automatic push_random(input int count);
        int added;
        int pick;
        int k;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                push_frame(1'b1, 1'b0);
                added += FRAME_BYTES;
            end else if (pick < 72) begin
                push_frame(1'b1, 1'b1);
                added += FRAME_BYTES;
            end else if (pick < 82) begin
                push_frame(1'b0, 1'($urandom_range(0, 1)));
                added += FRAME_BYTES;
            end else if (pick < 91) begin
                k = $urandom_range(1, 3);
                added += k;
                repeat (k) rx_bytes_pending.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(1, FRAME_BYTES - 2);
                rx_bytes_pending.push_back(cur_start);
                repeat (k) rx_bytes_pending.push_back(BYTE_W'($urandom_range(0, 255)));
                added += k + 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_bytes_pending.size() != 0 || s_valid || good_frames_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Drain, close any open frame with filler bytes, drain again
    task automatic settle_idle();
        wait_drained();
        if (rx_fill != 0) begin
            repeat (FRAME_BYTES - rx_fill)
                rx_bytes_pending.push_back(BYTE_W'($urandom_range(0, 255)));
            wait_drained();
        end
    endtask

    task automatic write_start(input logic [BYTE_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_start = value;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: noise while idle, all-zero frame, all-ones frame with sum wrap,
        // start byte repeated inside a frame
        rx_bytes_pending = '{8'h00, 8'hFF,
                             START_BYTE_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                             START_BYTE_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00,
                             START_BYTE_RESET, START_BYTE_RESET, 8'h01, 8'h02, 8'h03, 8'h04,
                             8'hB4, START_BYTE_RESET};
        settle_idle();

        push_random(400);
        settle_idle();

        // Zero start byte, with a long receiver hold-off while frames keep coming
        write_start(8'h00);
        push_random(350);
        long_hold_req = 1'b1;
        settle_idle();

        write_start(8'hFF);
        push_random(300);
        settle_idle();

        // Last stretch runs back to back on both sides
        write_start(BYTE_W'($urandom_range(1, 254)));
        no_idle = 1'b1;
        push_random(350);
        settle_idle();

        $display("Took %0d bytes over four start-byte settings (0xAA, 0x00, 0xFF, random);",
                 bytes_taken);
        $display("%0d good frames delivered, %0d field or frame mismatches.",
                 frames_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ufrsc_pkg.sv
rtl/ufrsc_collector.sv
rtl/ufrsc_out_reg.sv
rtl/uart_frame_receiver_sum_check_top.sv
tb/tb_top.sv
